// ===== sv/rgbhsv_pkg.sv =====
// Shared constants, types and the divider step function for the RGB to HSV converter.
`default_nettype none
package rgbhsv_pkg;

	localparam int unsigned CH_W       = 8;
	localparam int unsigned HUE_W      = 9;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned QUO_W      = 9;
	localparam int unsigned REM_W      = 17;
	localparam int unsigned DIV_STAGES = QUO_W;

	localparam logic [REM_W-1:0] SECTOR_SPAN  = 17'd60;
	localparam logic [REM_W-1:0] GREEN_OFFSET = 17'd120;
	localparam logic [REM_W-1:0] BLUE_OFFSET  = 17'd240;
	localparam logic [REM_W-1:0] CIRCLE_NUM   = 17'd360;
	localparam logic [REM_W-1:0] PERCENT_FULL = 17'd100;
	localparam logic [HUE_W-1:0] FULL_CIRCLE  = 9'd360;
	localparam logic [HUE_W-1:0] HUE_MAX      = 9'd359;
	localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;

	// Brightness is (100 * max + 127) / 255, done as a multiplication by the
	// reciprocal ceil(2^24 / 255) = 65794 and a shift by 24. Both the percent
	// scale and the rounding bias are folded into the constants.
	localparam logic [31:0]      VAL_MUL      = 32'd6579400;
	localparam logic [31:0]      VAL_BIAS     = 32'd8355838;
	localparam int unsigned      VAL_SHIFT    = 24;

	// Sector of the largest component.
	localparam logic [1:0] SEC_RED_LO = 2'd0;
	localparam logic [1:0] SEC_RED_HI = 2'd1;
	localparam logic [1:0] SEC_GREEN  = 2'd2;
	localparam logic [1:0] SEC_BLUE   = 2'd3;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [CH_W-1:0]  den;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t hue;
		div_lane_t sat;
	} div_word_t;

	// One restoring division step: tries the divisor shifted to quotient bit sh.
	function automatic div_lane_t div_step(div_lane_t a, int unsigned sh);
		logic [REM_W+QUO_W-1:0] trial;
		div_lane_t o;
		trial = {{(REM_W+QUO_W-CH_W){1'b0}}, a.den} << sh;
		o = a;
		if ({{QUO_W{1'b0}}, a.rem} >= trial) begin
			o.rem = a.rem - trial[REM_W-1:0];
			o.quo = a.quo | (QUO_W'(1) << sh);
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== sv/rgbhsv_ifs.sv =====
// Stream interfaces for RGB pixel words and HSV result words.
`default_nettype none
interface rgbhsv_rgb_if;
	import rgbhsv_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if;
	import rgbhsv_pkg::*;
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;
	logic [PCT_W-1:0] saturation;
	logic [PCT_W-1:0] brightness;
	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface
`default_nettype wire

// ===== sv/rgb_to_hsv_pixel_top.sv =====
// Pipelined RGB to HSV pixel converter, top level.
//
// The pix channel takes one RGB word of 8-bit channels per handshake (valid and ready high at
// a rising edge of clk). The hsv channel gives one word for each pixel, in order:
// hue in whole degrees 0 to 359, saturation and brightness in whole percent.
// Every rounding is half away from zero and exact.
// The pipeline has twelve register stages: the extremes and sector are found in
// stage one, the numerators and the brightness are formed in stage two (the
// brightness by a reciprocal multiplication), nine stages of a restoring divider
// each resolve one quotient bit for the hue and saturation quotients at once, and
// the last stage wraps the hue and holds the result word.
// Throughput is one pixel per cycle while the receiver does not stall; the divider chain is fully pipelined.
// When the receiver stalls, the whole pipeline holds and pix.ready drops in the
// same cycle, so no word is lost or repeated; ready returns as soon as the held
// result word is taken.
// Reset (arst_n low) clears all valid bits at once; data registers keep no reset.
`default_nettype none
module rgb_to_hsv_pixel_top (
	input  wire         clk,
	input  wire         arst_n,
	rgbhsv_rgb_if.sink  pix,
	rgbhsv_hsv_if.source hsv
);
	import rgbhsv_pkg::*;

	logic adv;
	logic out_v_q;

	// Stage one: extremes, spread and sector.
	logic             v_s1;
	logic [CH_W-1:0]  r_s1, g_s1, b_s1, mx_s1, delta_s1;
	logic [1:0]       sec_s1;

	// Stage two and the divider chain. Index 0 is stage two.
	logic      div_v_s [0:DIV_STAGES];
	div_word_t div_s   [0:DIV_STAGES];
	// Brightness travels beside the divider, already final.
	logic [PCT_W-1:0] val_s [0:DIV_STAGES];

	logic [HUE_W-1:0] hue_q;
	logic [PCT_W-1:0] sat_q, val_q;

	// The pipeline moves whenever the output register is empty or being taken.
	assign adv       = !out_v_q || hsv.ready;
	assign pix.ready = adv;

	logic [CH_W-1:0] mx_c, mn_c;
	logic [1:0]      sec_c;

	always_comb begin
		mx_c = pix.red;
		mn_c = pix.red;
		if (pix.green > mx_c) mx_c = pix.green;
		if (pix.blue > mx_c) mx_c = pix.blue;
		if (pix.green < mn_c) mn_c = pix.green;
		if (pix.blue < mn_c) mn_c = pix.blue;
		// Red wins ties, then green.
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sec_c = (pix.blue <= pix.green) ? SEC_RED_LO : SEC_RED_HI;
		end else if (pix.green >= pix.blue) begin
			sec_c = SEC_GREEN;
		end else begin
			sec_c = SEC_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1     <= pix.red;
			g_s1     <= pix.green;
			b_s1     <= pix.blue;
			mx_s1    <= mx_c;
			delta_s1 <= mx_c - mn_c;
			sec_s1   <= sec_c;
		end
	end

	// Numerators are pre-biased by half the divisor so a floor division rounds.
	logic [REM_W-1:0] d17, r17, g17, b17, mx17, hue_num;
	logic [31:0]      val_prod;
	logic [PCT_W-1:0] val_c;
	div_word_t        front_c;

	always_comb begin
		d17  = {{(REM_W-CH_W){1'b0}}, delta_s1};
		r17  = {{(REM_W-CH_W){1'b0}}, r_s1};
		g17  = {{(REM_W-CH_W){1'b0}}, g_s1};
		b17  = {{(REM_W-CH_W){1'b0}}, b_s1};
		mx17 = {{(REM_W-CH_W){1'b0}}, mx_s1};
		case (sec_s1)
			SEC_RED_LO: hue_num = SECTOR_SPAN * (g17 - b17);
			SEC_RED_HI: hue_num = CIRCLE_NUM * d17 - SECTOR_SPAN * (b17 - g17);
			SEC_GREEN:  hue_num = GREEN_OFFSET * d17 + SECTOR_SPAN * b17 - SECTOR_SPAN * r17;
			SEC_BLUE:   hue_num = BLUE_OFFSET * d17 + SECTOR_SPAN * r17 - SECTOR_SPAN * g17;
			default:    hue_num = '0;
		endcase

		front_c.hue.quo = '0;
		front_c.sat.quo = '0;
		// A grey pixel has no hue; divide zero by one instead.
		if (delta_s1 == '0) begin
			front_c.hue.rem = '0;
			front_c.hue.den = CH_W'(1);
		end else begin
			front_c.hue.rem = hue_num + (d17 >> 1);
			front_c.hue.den = delta_s1;
		end
		// A black pixel has no saturation.
		if (mx_s1 == '0) begin
			front_c.sat.rem = '0;
			front_c.sat.den = CH_W'(1);
		end else begin
			front_c.sat.rem = PERCENT_FULL * d17 + (mx17 >> 1);
			front_c.sat.den = mx_s1;
		end

		// The reciprocal error stays far below one step of 1/255 over the
		// whole input range, so the shifted product is the exact quotient.
		val_prod = {{(32-CH_W){1'b0}}, mx_s1} * VAL_MUL + VAL_BIAS;
		val_c    = val_prod[VAL_SHIFT +: PCT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (adv) begin
			div_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= front_c;
			val_s[0] <= val_c;
		end
	end

	// Each divider stage resolves one quotient bit, most significant first.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (adv) begin
				div_v_s[k] <= div_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k].hue <= div_step(div_s[k-1].hue, QUO_W - k);
				div_s[k].sat <= div_step(div_s[k-1].sat, QUO_W - k);
				val_s[k]     <= val_s[k-1];
			end
		end
	end

	// A hue that rounds up to a full circle wraps to zero.
	logic [HUE_W-1:0] hue_c;

	always_comb begin
		hue_c = div_s[DIV_STAGES].hue.quo;
		if (hue_c >= FULL_CIRCLE) hue_c = hue_c - FULL_CIRCLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= div_v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q <= hue_c;
			sat_q <= div_s[DIV_STAGES].sat.quo[PCT_W-1:0];
			val_q <= val_s[DIV_STAGES];
		end
	end

	assign hsv.valid      = out_v_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.brightness = val_q;

endmodule
`default_nettype wire

// ===== sv/rgbhsv_checker.sv =====
// Port-level checks for the RGB to HSV converter and their binding to the top level.
`default_nettype none
module rgbhsv_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [rgbhsv_pkg::HUE_W-1:0]  hue,
	input wire [rgbhsv_pkg::PCT_W-1:0]  saturation,
	input wire [rgbhsv_pkg::PCT_W-1:0]  brightness
);
	import rgbhsv_pkg::*;

	// A result word waiting on a stalled receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// The input side is open exactly when the result register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output stall");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue <= HUE_MAX)
		else $error("hue out of range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (saturation <= PCT_MAX && brightness <= PCT_MAX))
		else $error("percentage out of range");

endmodule

bind rgb_to_hsv_pixel_top rgbhsv_checker u_rgbhsv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (pix.ready),
	.out_valid  (hsv.valid),
	.out_ready  (hsv.ready),
	.hue        (hsv.hue),
	.saturation (hsv.saturation),
	.brightness (hsv.brightness)
);
`default_nettype wire

// ===== verif/tb_rgb_to_hsv_pixel_top.sv =====
// Testbench for the RGB to HSV pixel converter: directed and random pixels, checked in order.
module tb_rgb_to_hsv_pixel_top;
	import rgbhsv_pkg::*;

	// One pixel and the HSV word that it should turn into.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_word_t;

	localparam int unsigned RANDOM_PIXELS = 1100;
	localparam int unsigned STALL_LIMIT   = 5000;
	localparam int unsigned DRAIN_CYCLES  = 40;

	logic clk;
	logic arst_n;

	rgbhsv_rgb_if pix ();
	rgbhsv_hsv_if hsv ();

	rgb_to_hsv_pixel_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix.sink),
		.hsv    (hsv.source)
	);

	pixel_t    pending_pixels[$];
	hsv_word_t expected_hsv[$];
	int unsigned error_count;
	int unsigned idle_cycles;
	bit stimulus_done;
	bit pix_taken;

	always #5 clk = ~clk;

	// Rounds num/den half away from zero; num is never negative here.
	function automatic int unsigned div_round(int unsigned num, int unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	// Predicts the HSV word for one pixel.
	function automatic hsv_word_t convert_pixel(pixel_t p);
		int unsigned r, g, b, hi, lo, delta, h;
		hsv_word_t o;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		delta = hi - lo;
		o.brightness = PCT_W'(div_round(hi * 100, 255));
		o.saturation = (hi == 0) ? '0 : PCT_W'(div_round(delta * 100, hi));
		// Red wins ties for the largest component, then green.
		if (delta == 0)
			h = 0;
		else if (r == hi) begin
			if (b <= g)
				h = div_round(60 * (g - b), delta);
			else
				h = div_round(360 * delta - 60 * (b - g), delta);
		end else if (g == hi)
			h = div_round(120 * delta + 60 * b - 60 * r, delta);
		else
			h = div_round(240 * delta + 60 * r - 60 * g, delta);
		// A hue that rounds up to a full circle wraps to zero.
		if (h >= 360)
			h = h - 360;
		o.hue = HUE_W'(h);
		return o;
	endfunction

	// Gap lengths: mostly none or short, now and then long.
	function automatic int unsigned gap_length();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 0;
		else if (pick < 95)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 10);
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int unsigned kind;
		p = pixel_t'(24'($urandom));
		kind = $urandom_range(9);
		// Some pixels are steered into ties, greys and extreme codes.
		case (kind)
			0: begin
				p.green = p.red;
			end
			1: begin
				p.blue = p.green;
			end
			2: begin
				p.green = p.red;
				p.blue = p.red;
			end
			3: begin
				p.red = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			4: begin
				p.blue = p.red;
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	// Input acceptance is taken at the rising edge, where the handshake counts.
	always @(posedge clk) begin
		pix_taken = arst_n && pix.valid && pix.ready;
		if (pix_taken)
			expected_hsv.push_back(convert_pixel(pending_pixels.pop_front()));
	end

	// Driver: offers the oldest pending pixel, with random gaps between words.
	int unsigned send_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (pix_taken)
				send_gap = gap_length();
			if (pix.valid && !pix_taken) begin
				// The word on offer stays as it is until it is taken.
			end else if (send_gap > 0 || pending_pixels.size() == 0) begin
				if (send_gap > 0)
					send_gap = send_gap - 1;
				pix.valid <= 1'b0;
			end else begin
				pix.valid <= 1'b1;
				pix.red   <= pending_pixels[0].red;
				pix.green <= pending_pixels[0].green;
				pix.blue  <= pending_pixels[0].blue;
			end
		end
	end

	// Monitor: the rising edge samples both handshakes and checks each result word.
	hsv_word_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (hsv.valid && hsv.ready) begin
				if (expected_hsv.size() == 0) begin
					$error("result word with no pixel waiting: hue %0d", hsv.hue);
					error_count++;
				end else begin
					// The latency keeps any result well behind the expectation
					// that its pixel pushed.
					want = expected_hsv.pop_front();
					if (hsv.hue !== want.hue) begin
						$error("hue: expected %0d, got %0d", want.hue, hsv.hue);
						error_count++;
					end
					if (hsv.saturation !== want.saturation) begin
						$error("saturation: expected %0d, got %0d",
							want.saturation, hsv.saturation);
						error_count++;
					end
					if (hsv.brightness !== want.brightness) begin
						$error("brightness: expected %0d, got %0d",
							want.brightness, hsv.brightness);
						error_count++;
					end
				end
			end
			if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Receiver: random stalls, plus one long hold-off while pixels keep coming,
	// so that the pipeline fills up and pix.ready drops.
	int unsigned recv_gap;
	int unsigned hold_count;
	always @(negedge clk) begin
		if (!arst_n) begin
			hsv.ready <= 1'b0;
			recv_gap = 0;
			hold_count = 0;
		end else if (hold_count < 60 && pending_pixels.size() < 600 && !stimulus_done) begin
			hold_count++;
			hsv.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			hsv.ready <= 1'b0;
		end else begin
			hsv.ready <= 1'b1;
			recv_gap = gap_length();
		end
	end

	// Watchdog: too long with no word moving on either side ends the run.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_rgb_to_hsv_pixel_top: FAIL");
			$finish;
		end
	end

	pixel_t p;
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		hsv.ready = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		stimulus_done = 1'b0;
		pix_taken = 1'b0;

		// Directed pixels: black, white, greys, pure colors, ties and sector edges.
		pending_pixels.push_back('{8'h00, 8'h00, 8'h00});
		pending_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
		pending_pixels.push_back('{8'h80, 8'h80, 8'h80});
		pending_pixels.push_back('{8'h01, 8'h01, 8'h01});
		pending_pixels.push_back('{8'hFF, 8'h00, 8'h00});
		pending_pixels.push_back('{8'h00, 8'hFF, 8'h00});
		pending_pixels.push_back('{8'h00, 8'h00, 8'hFF});
		pending_pixels.push_back('{8'hFF, 8'hFF, 8'h00});
		pending_pixels.push_back('{8'h00, 8'hFF, 8'hFF});
		pending_pixels.push_back('{8'hFF, 8'h00, 8'hFF});
		pending_pixels.push_back('{8'hFF, 8'h00, 8'h01});
		pending_pixels.push_back('{8'hFF, 8'h01, 8'h00});
		pending_pixels.push_back('{8'hFF, 8'h01, 8'h01});
		pending_pixels.push_back('{8'hFF, 8'hFE, 8'hFF});
		pending_pixels.push_back('{8'hFE, 8'hFF, 8'hFF});
		pending_pixels.push_back('{8'h01, 8'h00, 8'h00});
		pending_pixels.push_back('{8'h00, 8'h01, 8'h00});
		pending_pixels.push_back('{8'h00, 8'h00, 8'h01});
		pending_pixels.push_back('{8'hAA, 8'h55, 8'hAA});
		pending_pixels.push_back('{8'h55, 8'hAA, 8'h55});
		pending_pixels.push_back('{8'hC8, 8'h02, 8'h03});
		pending_pixels.push_back('{8'h7F, 8'h80, 8'h81});
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			p = random_pixel();
			pending_pixels.push_back(p);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_pixels.size() == 0);
		stimulus_done = 1'b1;
		wait (expected_hsv.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_hsv.size() == 0)
			$display("tb_rgb_to_hsv_pixel_top: PASS");
		else
			$display("tb_rgb_to_hsv_pixel_top: FAIL");
		$finish;
	end

endmodule

// ===== rgb_to_hsv_pixel_top.f =====
sv/rgbhsv_pkg.sv
sv/rgbhsv_ifs.sv
sv/rgb_to_hsv_pixel_top.sv
sv/rgbhsv_checker.sv
verif/tb_rgb_to_hsv_pixel_top.sv
